// File: design/rpa_pkg.sv
// Shared types and constants for the reference-counted page allocator.
// Used by the front classifier, the request queue, the back end and the top level.
// Depends on nothing.
`default_nettype none

package rpa_pkg;

	localparam int PAGE_W   = 20;
	localparam int ADDR_W   = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 40;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADDREF = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

	localparam logic [1:0] CFG_BASE  = 2'd0;
	localparam logic [1:0] CFG_FIRST = 2'd1;
	localparam logic [1:0] CFG_TOP   = 2'd2;

	localparam logic [PAGE_W-1:0] BASE_RESET  = 20'd524288;
	localparam logic [PAGE_W-1:0] FIRST_RESET = 20'd524288;
	localparam logic [PAGE_W-1:0] TOP_RESET   = 20'd557056;

	typedef enum logic [1:0] {
		K_ALLOC,
		K_FREE,
		K_ADDREF,
		K_DONE
	} kind_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_STACK,
		BK_COUNT
	} back_state_t;

	typedef struct packed {
		logic [PAGE_W-1:0] base;
		logic [PAGE_W-1:0] first;
		logic [PAGE_W-1:0] top;
	} cfg_t;

	typedef struct packed {
		kind_t               kind;
		logic [PAGE_W-1:0]   idx;
		logic [STATUS_W-1:0] status;
	} req_t;

endpackage

`default_nettype wire

// File: design/refcounted_page_allocator_unit.sv
// Top level of the reference-counted page frame allocator.
// Instantiates rpa_front, rpa_queue and rpa_back; uses rpa_pkg.
// Usage: requests enter on the s_t* stream (cmd = 0 allocate, 1 free,
// 2 add reference; addr is the page byte address). Every request gives
// exactly one result on the m_t* stream: page_addr, status and released.
// Three configuration registers (region base page, first free page, top
// page) are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high. Writing the top page also reloads the allocation watermark.
// Configuration should only change while no request is in flight.
// After reset the count table is cleared one entry per clock, NUM_PAGES
// entries (32768 by default); s_tready stays low until it ends. Free, add
// reference, rejected requests and allocation from the watermark read only
// the count memory; allocation from the free stack reads the stack memory
// before the count memory. The back end handles one request at a time, so
// it takes no new request from the queue before the last one is committed.
// A two-entry queue decouples the front from the back, and a result register
// holds a finished result while the receiver stalls; the back end waits on a
// full result register and the queue fills before s_tready drops.
`default_nettype none

module refcounted_page_allocator_unit #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int COUNT_BITS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// [1:0] cmd, [33:2] addr, [39:34] zero
	input  wire logic [rpa_pkg::IN_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [31:0] page_addr, [34:32] status, [35] released, [39:36] zero
	output logic [rpa_pkg::OUT_W-1:0]       m_tdata,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [rpa_pkg::PAGE_W-1:0] cfg_data
);
	import rpa_pkg::*;

	cfg_t  cfg_q;
	logic  cfg_wr;
	logic  mark_load;
	logic  clearing;
	logic  q_full, q_valid, q_pop, push;
	req_t  push_item, q_item;

	// Configuration registers; every transfer is taken at once.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign mark_load = cfg_wr && (cfg_index == CFG_TOP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base  <= BASE_RESET;
			cfg_q.first <= FIRST_RESET;
			cfg_q.top   <= TOP_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_BASE:  cfg_q.base  <= cfg_data;
				CFG_FIRST: cfg_q.first <= cfg_data;
				CFG_TOP:   cfg_q.top   <= cfg_data;
				default:   cfg_q       <= cfg_q;
			endcase
		end
	end

	// Front end classifies requests and does the address checks.
	rpa_front #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg_q),
		.clearing (clearing),
		.q_full   (q_full),
		.push     (push),
		.push_item(push_item)
	);

	rpa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.valid    (q_valid),
		.item     (q_item),
		.pop      (q_pop)
	);

	// Back end owns the count table, free stack and watermark.
	rpa_back #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mark_load (mark_load),
		.mark_value(cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef ASSERT_OFF
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_tready)
		else $error("request accepted during count table clearing");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[35]) |-> (m_tdata[34:32] == ST_OK))
		else $error("released flag set with an error status");

	a_error_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[34:32] != ST_OK)) |-> (m_tdata[31:0] == '0))
		else $error("page address returned with an error status");
`endif

endmodule

`default_nettype wire

// File: design/rpa_front.sv
// Front end: decodes each incoming request and runs the address checks
// that depend only on configuration. Uses rpa_pkg.
`default_nettype none

module rpa_front #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [rpa_pkg::IN_W-1:0] s_tdata,
	input  wire rpa_pkg::cfg_t          cfg,
	input  wire logic                   clearing,
	input  wire logic                   q_full,
	output logic                        push,
	output rpa_pkg::req_t               push_item
);
	import rpa_pkg::*;

	localparam int CMP_W = 33;

	logic [CMD_W-1:0]  cmd;
	logic [ADDR_W-1:0] addr;
	logic [CMP_W-1:0]  page_ext;
	logic [CMP_W-1:0]  base_ext;
	logic [CMP_W-1:0]  diff;
	logic              aligned;
	logic              in_region;
	logic              below_top;
	logic              above_first;

	assign cmd  = s_tdata[CMD_W-1:0];
	assign addr = s_tdata[CMD_W+ADDR_W-1:CMD_W];

	assign s_tready = !clearing && !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		page_ext    = CMP_W'(addr >> PAGE_SHIFT);
		base_ext    = CMP_W'(cfg.base);
		diff        = page_ext - base_ext;
		aligned     = (addr[PAGE_SHIFT-1:0] == '0);
		in_region   = (page_ext >= base_ext) && (diff < CMP_W'(NUM_PAGES));
		below_top   = page_ext < CMP_W'(cfg.top);
		above_first = page_ext >= CMP_W'(cfg.first);

		push_item.idx    = diff[PAGE_W-1:0];
		push_item.status = ST_OK;
		push_item.kind   = K_DONE;
		case (cmd)
			CMD_ALLOC: begin
				push_item.kind = K_ALLOC;
			end
			CMD_FREE: begin
				if (aligned && above_first && below_top && in_region) begin
					push_item.kind = K_FREE;
				end else begin
					push_item.status = ST_BAD_ADDR;
				end
			end
			CMD_ADDREF: begin
				if (below_top && in_region) begin
					push_item.kind = K_ADDREF;
				end else begin
					push_item.status = ST_BAD_ADDR;
				end
			end
			default: begin
				push_item.kind = K_DONE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/rpa_queue.sv
// Two-entry request queue between the front end and the back end.
// Uses rpa_pkg for the request record.
`default_nettype none

module rpa_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rpa_pkg::req_t push_item,
	output logic               full,
	output logic               valid,
	output rpa_pkg::req_t      item,
	input  wire logic          pop
);
	import rpa_pkg::*;

	req_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/rpa_back.sv
// Back end: count table and free-page stack memories, the watermark, the
// clearing pass after reset and the result register. Uses rpa_pkg.
`default_nettype none

module rpa_back #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int COUNT_BITS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire rpa_pkg::cfg_t           cfg,
	input  wire logic                    mark_load,
	input  wire logic [rpa_pkg::PAGE_W-1:0] mark_value,
	input  wire logic                    q_valid,
	input  wire rpa_pkg::req_t           q_item,
	output logic                         q_pop,
	output logic                         clearing,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [rpa_pkg::OUT_W-1:0]    m_tdata
);
	import rpa_pkg::*;

	localparam int IDX_W   = $clog2(NUM_PAGES);
	localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] count_mem [NUM_PAGES];
	logic [IDX_W-1:0]      stack_mem [NUM_PAGES];

	back_state_t          state_q, state_d;
	logic [IDX_W-1:0]     clr_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [PAGE_W-1:0]    mark_q;
	kind_t                kind_q;
	logic [IDX_W-1:0]     idx_q;
	logic [STATUS_W-1:0]  pend_q;
	logic                 from_stack_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [IDX_W-1:0]     stk_rd_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic                 ld_item, ld_stack_idx, commit;
	logic                 cnt_rd_en, stk_rd_en;
	logic [IDX_W-1:0]     cnt_rd_addr;
	logic [IDX_W-1:0]     item_idx;
	logic [STATUS_W-1:0]  item_status;
	logic                 item_from_stack;
	logic [DEPTH_W-1:0]   depth_m1;
	logic [PAGE_W-1:0]    mark_page;
	logic [PAGE_W-1:0]    mark_diff;
	logic                 mark_ok;

	logic                  cnt_we, stk_we, dep_inc, dep_dec, mark_dec, res_rel;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic [STATUS_W-1:0]   res_status;
	logic [ADDR_W-1:0]     page_sum;
	logic [ADDR_W-1:0]     res_page;

	assign clearing = (state_q == BK_CLEAR);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Classification of the queue head against the stack and the watermark.
	always_comb begin
		depth_m1        = depth_q - DEPTH_W'(1);
		mark_page       = mark_q - PAGE_W'(1);
		mark_diff       = mark_page - cfg.base;
		mark_ok         = (mark_q > cfg.first) && (mark_page >= cfg.base) &&
		                  ({1'b0, mark_diff} < (PAGE_W+1)'(NUM_PAGES));
		item_from_stack = (q_item.kind == K_ALLOC) && (depth_q != '0);
		item_idx        = q_item.idx[IDX_W-1:0];
		item_status     = q_item.status;
		if (q_item.kind == K_ALLOC && !item_from_stack) begin
			item_idx    = mark_diff[IDX_W-1:0];
			item_status = mark_ok ? ST_OK : ST_NO_PAGE;
		end
	end

	// Sequencer: next state and strobes.
	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		ld_item      = 1'b0;
		ld_stack_idx = 1'b0;
		commit       = 1'b0;
		cnt_rd_en    = 1'b0;
		stk_rd_en    = 1'b0;
		cnt_rd_addr  = item_idx;
		case (state_q)
			BK_CLEAR: begin
				if (clr_q == IDX_W'(NUM_PAGES - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					ld_item = 1'b1;
					if (item_from_stack) begin
						stk_rd_en = 1'b1;
						state_d   = BK_STACK;
					end else begin
						cnt_rd_en = 1'b1;
						state_d   = BK_COUNT;
					end
				end
			end
			BK_STACK: begin
				cnt_rd_en    = 1'b1;
				cnt_rd_addr  = stk_rd_q;
				ld_stack_idx = 1'b1;
				state_d      = BK_COUNT;
			end
			BK_COUNT: begin
				if (!out_valid_q || m_tready) begin
					commit  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_CLEAR;
			end
		endcase
	end

	// Outcome of the read-modify-write on the count.
	always_comb begin
		res_status = pend_q;
		res_page   = '0;
		res_rel    = 1'b0;
		cnt_we     = 1'b0;
		cnt_wd     = '0;
		stk_we     = 1'b0;
		dep_inc    = 1'b0;
		dep_dec    = 1'b0;
		mark_dec   = 1'b0;
		page_sum   = ADDR_W'(cfg.base) + ADDR_W'(idx_q);
		if (pend_q == ST_OK) begin
			case (kind_q)
				K_ALLOC: begin
					if (cnt_rd_q != '0) begin
						res_status = ST_BAD_COUNT;
					end else begin
						cnt_we   = 1'b1;
						cnt_wd   = COUNT_BITS'(1);
						dep_dec  = from_stack_q;
						mark_dec = !from_stack_q;
						res_page = page_sum << PAGE_SHIFT;
					end
				end
				K_FREE: begin
					if (cnt_rd_q == '0) begin
						res_status = ST_BAD_COUNT;
					end else begin
						cnt_we = 1'b1;
						cnt_wd = cnt_rd_q - COUNT_BITS'(1);
						if (cnt_rd_q == COUNT_BITS'(1)) begin
							res_rel = 1'b1;
							if (depth_q < DEPTH_W'(NUM_PAGES)) begin
								stk_we  = 1'b1;
								dep_inc = 1'b1;
							end
						end
					end
				end
				K_ADDREF: begin
					if (cnt_rd_q == '0) begin
						res_status = ST_BAD_COUNT;
					end else if (cnt_rd_q == CNT_MAX) begin
						res_status = ST_OVERFLOW;
					end else begin
						cnt_we = 1'b1;
						cnt_wd = cnt_rd_q + COUNT_BITS'(1);
					end
				end
				default: begin
					res_status = pend_q;
				end
			endcase
		end
	end

	// Count table: one write port (clearing pass or commit), one read port.
	always_ff @(posedge clk) begin
		if (clearing) begin
			count_mem[clr_q] <= '0;
		end else if (commit && cnt_we) begin
			count_mem[idx_q] <= cnt_wd;
		end
		if (cnt_rd_en) begin
			cnt_rd_q <= count_mem[cnt_rd_addr];
		end
	end

	// Free-page stack.
	always_ff @(posedge clk) begin
		if (commit && stk_we) begin
			stack_mem[depth_q[IDX_W-1:0]] <= idx_q;
		end
		if (stk_rd_en) begin
			stk_rd_q <= stack_mem[depth_m1[IDX_W-1:0]];
		end
	end

	// Request record held while the back end works on it.
	always_ff @(posedge clk) begin
		if (ld_item) begin
			kind_q       <= q_item.kind;
			idx_q        <= item_idx;
			pend_q       <= item_status;
			from_stack_q <= item_from_stack;
		end else if (ld_stack_idx) begin
			idx_q <= stk_rd_q;
		end
		if (commit) begin
			out_data_q <= OUT_W'({res_rel, res_status, res_page});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			depth_q     <= '0;
			mark_q      <= TOP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (commit && dep_inc) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end else if (commit && dep_dec) begin
				depth_q <= depth_m1;
			end
			if (mark_load) begin
				mark_q <= mark_value;
			end else if (commit && mark_dec) begin
				mark_q <= mark_page;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
